FILE: rtl/obb_pkg.sv
package obb_pkg;

  localparam int NUM_STAGES = 7;

  localparam logic [127:0] TRILLION = 128'd1000000000000;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TEST = 1'b1
  } obb_kind_e;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } obb_pipe_t;

endpackage

FILE: rtl/obb_if.sv
interface obb_in_if #(
  parameter int CW = 32,
  parameter int AW = 16
);
  logic                valid;
  logic                ready;
  logic                kind;
  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic signed [CW-1:0] center_z;
  logic [3*AW-1:0]     axis_u;
  logic [3*AW-1:0]     axis_v;
  logic [3*AW-1:0]     axis_w;
  logic [CW-2:0]       half_x;
  logic [CW-2:0]       half_y;
  logic [CW-2:0]       half_z;

  modport source (
    output valid, kind, center_x, center_y, center_z, axis_u, axis_v, axis_w,
           half_x, half_y, half_z,
    input  ready
  );
  modport sink (
    input  valid, kind, center_x, center_y, center_z, axis_u, axis_v, axis_w,
           half_x, half_y, half_z,
    output ready
  );
endinterface

interface obb_out_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink (input valid, overlap, output ready);
endinterface

FILE: rtl/obb_pipe_ctrl.sv
module obb_pipe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_test_i,
  input  logic               out_ready_i,
  output logic               in_ready_o,
  output obb_pkg::obb_pipe_t pipe_o
);
  import obb_pkg::*;

  logic [NUM_STAGES-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
    vld_d = vld_q;
    if (en[0]) begin
      vld_d[0] = in_valid_i && in_test_i;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o = en[0];
  assign pipe_o.en  = en;
  assign pipe_o.vld = vld_q;

endmodule

FILE: rtl/obb_cross.sv
module obb_cross #(
  parameter int AW = 16
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [AW-1:0] a_i [3],
  input  logic signed [AW-1:0] b_i [3],
  output logic signed [2*AW:0] c_o [3]
);
  localparam int PW = 2 * AW;
  localparam int XW = 2 * AW + 1;

  logic signed [PW-1:0] p_q [6];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= PW'(a_i[1]) * PW'(b_i[2]);
      p_q[1] <= PW'(a_i[2]) * PW'(b_i[1]);
      p_q[2] <= PW'(a_i[2]) * PW'(b_i[0]);
      p_q[3] <= PW'(a_i[0]) * PW'(b_i[2]);
      p_q[4] <= PW'(a_i[0]) * PW'(b_i[1]);
      p_q[5] <= PW'(a_i[1]) * PW'(b_i[0]);
    end
  end

  assign c_o[0] = XW'(p_q[0]) - XW'(p_q[1]);
  assign c_o[1] = XW'(p_q[2]) - XW'(p_q[3]);
  assign c_o[2] = XW'(p_q[4]) - XW'(p_q[5]);

endmodule

FILE: rtl/obb_lane.sv
module obb_lane #(
  parameter int CW = 32,
  parameter int AW = 16
) (
  input  logic                  clk_i,
  input  obb_pkg::obb_pipe_t    pipe_i,
  input  logic signed [2*AW:0]  axis_i [3],
  input  logic signed [CW:0]    d_i [3],
  input  logic signed [AW-1:0]  e_i [6][3],
  input  logic [CW-2:0]         h_i [6],
  output logic [CW+2*AW+3:0]    dist_o,
  output logic [3*AW+CW+4:0]    rad_o,
  output logic                  short_o
);
  import obb_pkg::*;

  localparam int F   = AW - 2;
  localparam int XW  = 2 * AW + 1;
  localparam int DW  = CW + XW + 3;
  localparam int EW  = XW + AW + 2;
  localparam int PDW = CW + 1 + XW;
  localparam int PEW = XW + AW;
  localparam int PSW = 2 * XW;
  localparam int LW  = 2 * XW + 2;
  localparam int SPL = (EW + 1) / 2;
  localparam int HIW = EW - SPL;
  localparam int PLW = SPL + CW - 1;
  localparam int PHW = HIW + CW - 1;
  localparam int TW  = EW + CW - 1;
  localparam int RW  = EW + CW + 2;
  localparam logic [127:0] LEN_POW = 128'd1 << (4 * F);
  localparam logic [127:0] LEN_LIM = (LEN_POW - 128'd1) / TRILLION + 128'd1;

  logic signed [PDW-1:0] pd_q [3];
  logic signed [PEW-1:0] pe_q [6][3];
  logic signed [PSW-1:0] ps_q [3];

  logic signed [DW-1:0] dot_d;
  logic signed [EW-1:0] dot_e [6];
  logic [LW-1:0]        len2;

  logic [DW-1:0] mag_d4_q, mag_d5_q, mag_d6_q;
  logic [EW-1:0] mag_e_q [6];
  logic          short4_q, short5_q, short6_q;

  logic [PLW-1:0] plo_q [6];
  logic [PHW-1:0] phi_q [6];
  logic [TW-1:0]  term [6];
  logic [RW-1:0]  rad_sum, rad_q;

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[2]) begin
      for (int k = 0; k < 3; k++) begin
        pd_q[k] <= PDW'(d_i[k]) * PDW'(axis_i[k]);
        ps_q[k] <= PSW'(axis_i[k]) * PSW'(axis_i[k]);
        for (int m = 0; m < 6; m++) begin
          pe_q[m][k] <= PEW'(axis_i[k]) * PEW'(e_i[m][k]);
        end
      end
    end
  end

  always_comb begin
    dot_d = DW'(pd_q[0]) + DW'(pd_q[1]) + DW'(pd_q[2]);
    for (int m = 0; m < 6; m++) begin
      dot_e[m] = EW'(pe_q[m][0]) + EW'(pe_q[m][1]) + EW'(pe_q[m][2]);
    end
    len2 = LW'($unsigned(ps_q[0])) + LW'($unsigned(ps_q[1])) + LW'($unsigned(ps_q[2]));
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[3]) begin
      mag_d4_q <= dot_d[DW-1] ? DW'(-dot_d) : DW'(dot_d);
      for (int m = 0; m < 6; m++) begin
        mag_e_q[m] <= dot_e[m][EW-1] ? EW'(-dot_e[m]) : EW'(dot_e[m]);
      end
      short4_q <= 128'(len2) < LEN_LIM;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[4]) begin
      for (int m = 0; m < 6; m++) begin
        plo_q[m] <= PLW'(mag_e_q[m][SPL-1:0]) * PLW'(h_i[m]);
        phi_q[m] <= PHW'(mag_e_q[m][EW-1:SPL]) * PHW'(h_i[m]);
      end
      mag_d5_q <= mag_d4_q;
      short5_q <= short4_q;
    end
  end

  always_comb begin
    rad_sum = '0;
    for (int m = 0; m < 6; m++) begin
      term[m] = TW'({phi_q[m], {SPL{1'b0}}}) + TW'(plo_q[m]);
      rad_sum = rad_sum + RW'(term[m]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[5]) begin
      rad_q    <= rad_sum;
      mag_d6_q <= mag_d5_q;
      short6_q <= short5_q;
    end
  end

  assign dist_o  = mag_d6_q;
  assign rad_o   = rad_q;
  assign short_o = short6_q;

endmodule

FILE: rtl/obb_overlap_sat_core.sv
// Channel  Direction  Interface   Payload
// in_i     sink       obb_in_if   kind, center_x/y/z, axis_u/v/w, half_x/y/z
// out_o    source     obb_out_if  overlap
//
// One item is taken per cycle while in_i.ready is high; a test result is offered once it has passed the stages.
// A load item updates the reference box at its transfer and yields no result.
// The seven register stages are input capture, cross products, axis products,
// dot sums, radius partial products, radius sum and the final compare across 15 axis lanes.
// A full stage holds while the one after it is full and stalled, so bubbles collapse.
// Reset clears the reference box and all stage valid bits.
module obb_overlap_sat_core #(
  parameter int COORD_WIDTH = 32,
  parameter int AXIS_WIDTH  = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  obb_in_if.sink    in_i,
  obb_out_if.source out_o
);
  import obb_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int AW   = AXIS_WIDTH;
  localparam int F    = AW - 2;
  localparam int XW   = 2 * AW + 1;
  localparam int DW   = CW + XW + 3;
  localparam int RW   = 3 * AW + CW + 5;
  localparam int CMPW = (DW + F > RW) ? DW + F : RW;

  obb_pipe_t pipe;
  logic      in_ready;
  logic      in_xfer;

  logic signed [CW-1:0] ref_center_q [3];
  logic [3*AW-1:0]      ref_axes_q [3];
  logic [CW-2:0]        ref_half_q [3];

  logic signed [CW-1:0] in_center [3];
  logic [3*AW-1:0]      in_axes [3];
  logic [CW-2:0]        in_half [3];

  logic signed [CW:0]    d_s1_q [3], d_s2_q [3];
  logic signed [AW-1:0]  e_s1_q [6][3], e_s2_q [6][3];
  logic [CW-2:0]         h_s1_q [6], h_s2_q [6], h_s3_q [6], h_s4_q [6];
  logic signed [2*AW:0]  cross_c [9][3];
  logic signed [2*AW:0]  lane_axis [15][3];
  logic [DW-1:0]         lane_dist [15];
  logic [RW-1:0]         lane_rad [15];
  logic                  lane_short [15];
  logic [14:0]           sep;
  logic                  overlap_q;

  assign in_center[0] = in_i.center_x;
  assign in_center[1] = in_i.center_y;
  assign in_center[2] = in_i.center_z;
  assign in_axes[0]   = in_i.axis_u;
  assign in_axes[1]   = in_i.axis_v;
  assign in_axes[2]   = in_i.axis_w;
  assign in_half[0]   = in_i.half_x;
  assign in_half[1]   = in_i.half_y;
  assign in_half[2]   = in_i.half_z;

  assign in_xfer    = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  obb_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_test_i  (in_i.kind == KIND_TEST),
    .out_ready_i(out_o.ready),
    .in_ready_o (in_ready),
    .pipe_o     (pipe)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        ref_center_q[i] <= '0;
        ref_axes_q[i]   <= '0;
        ref_half_q[i]   <= '0;
      end
    end else if (in_xfer && in_i.kind == KIND_LOAD) begin
      for (int i = 0; i < 3; i++) begin
        ref_center_q[i] <= in_center[i];
        ref_axes_q[i]   <= in_axes[i];
        ref_half_q[i]   <= in_half[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe.en[0]) begin
      for (int i = 0; i < 3; i++) begin
        d_s1_q[i] <= (CW+1)'(in_center[i]) - (CW+1)'(ref_center_q[i]);
        h_s1_q[i]     <= ref_half_q[i];
        h_s1_q[i + 3] <= in_half[i];
        for (int k = 0; k < 3; k++) begin
          e_s1_q[i][k]     <= ref_axes_q[i][k*AW +: AW];
          e_s1_q[i + 3][k] <= in_axes[i][k*AW +: AW];
        end
      end
    end
    if (pipe.en[1]) begin
      d_s2_q <= d_s1_q;
      e_s2_q <= e_s1_q;
      h_s2_q <= h_s1_q;
    end
    if (pipe.en[2]) begin
      h_s3_q <= h_s2_q;
    end
    if (pipe.en[3]) begin
      h_s4_q <= h_s3_q;
    end
  end

  for (genvar x = 0; x < 9; x++) begin : g_cross
    obb_cross #(.AW(AW)) u_cross (
      .clk_i(clk_i),
      .en_i (pipe.en[1]),
      .a_i  (e_s1_q[x / 3]),
      .b_i  (e_s1_q[3 + x % 3]),
      .c_o  (cross_c[x])
    );
  end

  for (genvar l = 0; l < 15; l++) begin : g_lane
    for (genvar k = 0; k < 3; k++) begin : g_axis
      if (l < 6) begin : g_face
        assign lane_axis[l][k] = XW'(e_s2_q[l][k]);
      end else begin : g_xprod
        assign lane_axis[l][k] = cross_c[l - 6][k];
      end
    end

    obb_lane #(.CW(CW), .AW(AW)) u_lane (
      .clk_i  (clk_i),
      .pipe_i (pipe),
      .axis_i (lane_axis[l]),
      .d_i    (d_s2_q),
      .e_i    (e_s2_q),
      .h_i    (h_s4_q),
      .dist_o (lane_dist[l]),
      .rad_o  (lane_rad[l]),
      .short_o(lane_short[l])
    );

    assign sep[l] = (CMPW'({lane_dist[l], {F{1'b0}}}) > CMPW'(lane_rad[l]))
                    && !(lane_short[l] && (l >= 6));
  end

  always_ff @(posedge clk_i) begin
    if (pipe.en[6]) begin
      overlap_q <= ~|sep;
    end
  end

  assign out_o.valid   = pipe.vld[NUM_STAGES-1];
  assign out_o.overlap = overlap_q;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (&pipe.vld && !out_o.ready))
    else $error("input stalled while the pipeline has room");

  a_test_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.kind == KIND_TEST) |=> pipe.vld[0])
    else $error("test transfer did not enter the first stage");

  a_load_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.kind == KIND_LOAD) |=> !pipe.vld[0])
    else $error("load transfer entered the result pipeline");

  a_load_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.kind == KIND_LOAD) |=> ref_center_q[0] == $past(in_i.center_x))
    else $error("load transfer did not update the reference box");
`endif

endmodule
